// ===== design/rdsg0_pkg.sv =====
package rdsg0_pkg;

    // Port and field widths
    localparam int SampleW   = 16;
    localparam int CfgIdxW   = 4;
    localparam int CfgDataW  = 64;
    localparam int PiW       = 16;
    localparam int PtyW      = 5;
    localparam int AfW       = 16;
    localparam int PsW       = 64;

    // Group layout
    localparam int DataW     = 16;
    localparam int CheckW    = 10;
    localparam int BlockW    = DataW + CheckW;
    localparam int NumBlocks = 4;
    localparam int GroupBits = BlockW * NumBlocks;
    localparam int BitIdxW   = $clog2(GroupBits);
    localparam int SegW      = 2;

    localparam logic [3:0]      GroupType0 = 4'h0;
    localparam logic [SegW-1:0] SegLast    = 2'd3;
    localparam logic [DataW-1:0] DiStereo  = 16'h0005;

    // Check bits contributed by data bit i: x^(10+i) mod x^10+x^8+x^7+x^5+x^4+x^3+1
    localparam logic [CheckW-1:0] CheckSyn [DataW] = '{
        10'h1b9, 10'h372, 10'h35d, 10'h303, 10'h3bf, 10'h2c7, 10'h037, 10'h06e,
        10'h0dc, 10'h1b8, 10'h370, 10'h359, 10'h30b, 10'h3af, 10'h2e7, 10'h077
    };

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CfgPi  = 4'd0,
        CfgTp  = 4'd1,
        CfgPty = 4'd2,
        CfgTa  = 4'd3,
        CfgMs  = 4'd4,
        CfgAb  = 4'd5,
        CfgAf  = 4'd6,
        CfgPs  = 4'd7
    } t_cfg_idx;

    // Last seen sign of the reference tone
    typedef enum logic [1:0] {
        SignNone = 2'd0,
        SignPos  = 2'd1,
        SignNeg  = 2'd2
    } t_sign;

    typedef struct packed {
        logic [PiW-1:0]  pi;
        logic            tp;
        logic [PtyW-1:0] pty;
        logic            ta;
        logic            ms;
        logic            ab;
        logic [AfW-1:0]  af;
        logic [PsW-1:0]  ps;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        pi:  '0,
        tp:  1'b0,
        pty: '0,
        ta:  1'b0,
        ms:  1'b0,
        ab:  1'b0,
        af:  '0,
        ps:  64'h2020_2020_2020_2020
    };

    // Check word as an XOR of per-bit syndromes
    function automatic logic [CheckW-1:0] f_check(input logic [DataW-1:0] d);
        logic [CheckW-1:0] c;
        c = '0;
        for (int i = 0; i < DataW; i++) begin
            if (d[i]) begin
                c = c ^ CheckSyn[i];
            end
        end
        return c;
    endfunction

    function automatic logic [BlockW-1:0] f_block(input logic [DataW-1:0] d);
        return {d, f_check(d)};
    endfunction

    // Whole group, block one in the top bits, first bit sent at the MSB
    function automatic logic [GroupBits-1:0] f_build(input t_cfg cfg,
                                                     input logic [SegW-1:0] seg);
        logic [DataW-1:0] b1;
        logic [DataW-1:0] b2;
        logic [DataW-1:0] b3;
        b1 = {GroupType0, cfg.ab, cfg.tp, cfg.pty, cfg.ta, cfg.ms, 1'b0, seg};
        if (seg == SegLast) begin
            b1 = b1 | DiStereo;
        end
        b2 = cfg.ab ? cfg.pi : cfg.af;
        b3 = cfg.ps[(PsW - 1) - DataW * int'(seg) -: DataW];
        return {f_block(cfg.pi), f_block(b1), f_block(b2), f_block(b3)};
    endfunction

endpackage

// ===== design/rds_group0_bit_encoder_top.sv =====
// Timing: a sample passes through the input register, then the result register.
// Throughput: one sample per cycle while the output is ready; a new sample is
// taken while a result waits only if the input register is empty.
// Reset (synchronous, active low): registers but r_sample take reset values, the
// group for segment zero is loaded and no item is held in either stage.
module rds_group0_bit_encoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rdsg0_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [rdsg0_pkg::CfgDataW-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [rdsg0_pkg::SampleW-1:0] i_ref_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_rds_level
);
    import rdsg0_pkg::*;

    t_cfg                       r_cfg;
    logic                       r_s1_valid;
    logic signed [SampleW-1:0]  r_sample;
    logic                       r_out_valid;
    logic                       r_level;
    logic [GroupBits-1:0]       r_group;
    logic [SegW-1:0]            r_seg;
    logic [BitIdxW-1:0]         r_bit_idx;
    t_sign                      r_last_sign;
    logic                       r_xcount;

    logic                       w_s2_load;
    logic                       w_s1_ready;
    logic                       w_fire;
    t_sign                      w_sign;
    logic                       w_cross;
    logic                       w_adv;
    logic                       w_wrap;
    logic [BitIdxW-1:0]         w_idx_inc;
    logic [SegW-1:0]            w_seg_nxt;
    logic [GroupBits-1:0]       w_group_nxt;
    logic                       w_bit;

    logic                       n_level;
    logic [GroupBits-1:0]       n_group;
    logic [SegW-1:0]            n_seg;
    logic [BitIdxW-1:0]         n_bit_idx;
    logic                       n_xcount;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CfgPi:   r_cfg.pi  <= i_cfg_data[PiW-1:0];
                CfgTp:   r_cfg.tp  <= i_cfg_data[0];
                CfgPty:  r_cfg.pty <= i_cfg_data[PtyW-1:0];
                CfgTa:   r_cfg.ta  <= i_cfg_data[0];
                CfgMs:   r_cfg.ms  <= i_cfg_data[0];
                CfgAb:   r_cfg.ab  <= i_cfg_data[0];
                CfgAf:   r_cfg.af  <= i_cfg_data[AfW-1:0];
                CfgPs:   r_cfg.ps  <= i_cfg_data[PsW-1:0];
                default: r_cfg     <= r_cfg;
            endcase
        end
    end

    // Handshake between the input register and the result register
    assign w_s2_load  = !r_out_valid || i_out_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_load;
    assign w_fire     = r_s1_valid && w_s2_load;
    assign o_in_ready = w_s1_ready;

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_s1_ready) begin
            r_sample <= i_ref_sample;
        end
    end

    // Detect crossings; every second one advances a bit
    assign w_sign      = (r_sample > 0) ? SignPos : SignNeg;
    assign w_cross     = (w_sign != r_last_sign);
    assign w_adv       = w_cross && r_xcount;
    assign w_wrap      = (r_bit_idx == BitIdxW'(GroupBits - 1));
    assign w_idx_inc   = r_bit_idx + 1'b1;
    assign w_seg_nxt   = r_seg + 1'b1;
    assign w_group_nxt = f_build(r_cfg, w_seg_nxt);
    assign w_bit       = w_wrap ? w_group_nxt[GroupBits-1]
                                : r_group[BitIdxW'(GroupBits - 1) - w_idx_inc];

    // Next state of the encoder
    always_comb begin
        n_xcount  = w_cross ? !r_xcount : r_xcount;
        n_level   = r_level;
        n_group   = r_group;
        n_seg     = r_seg;
        n_bit_idx = r_bit_idx;
        if (w_adv) begin
            n_level = r_level ^ w_bit;
            if (w_wrap) begin
                n_bit_idx = '0;
                n_seg     = w_seg_nxt;
                n_group   = w_group_nxt;
            end else begin
                n_bit_idx = w_idx_inc;
            end
        end
    end

    // Advance the encoder and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= CfgReset.pi[PiW-1];
            r_group     <= f_build(CfgReset, '0);
            r_seg       <= '0;
            r_bit_idx   <= '0;
            r_last_sign <= SignNone;
            r_xcount    <= 1'b0;
        end else begin
            if (w_s2_load) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_fire) begin
                r_level     <= n_level;
                r_group     <= n_group;
                r_seg       <= n_seg;
                r_bit_idx   <= n_bit_idx;
                r_last_sign <= w_sign;
                r_xcount    <= n_xcount;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rds_level = r_level;

endmodule

// ===== design/rdsg0_checker.sv =====
module rdsg0_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_rds_level
);

    logic [2:0] r_inflight;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Track items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + {2'b00, w_in_acc} - {2'b00, w_out_acc};
        end
    end

    // A stalled result holds its level
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rds_level))
        else $error("result changed while stalled");

    // No result without an item behind it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != 3'd0)
        else $error("result without a pending item");

    // At most two items between input and output
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd2)
        else $error("too many items in flight");

    // An empty result register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no result pending");

    // Configuration is always taken
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind rds_group0_bit_encoder_top rdsg0_checker u_rdsg0_checker (.*);

// ===== tb/tb_rds_group0_bit_encoder_top.sv =====
`timescale 1ns / 1ps

module tb_rds_group0_bit_encoder_top;
    import rdsg0_pkg::*;

    localparam int HalfPeriod  = 2;
    localparam int ResetCycles = 5;
    localparam int QuietLimit  = 500;
    localparam int PhaseItems  = 140;
    localparam int RandItems   = 650;
    localparam int RandCap     = 2000;
    localparam int TailCycles  = 8;
    localparam int MaxIdle     = 5;

    localparam logic [CheckW:0]    CheckPoly = 11'h5b9;
    // Indexes past the register file; writes there must be dropped
    localparam logic [CfgIdxW-1:0] CfgNoSuch = 4'd8;
    localparam logic [CfgIdxW-1:0] CfgTopIdx = 4'd15;

    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic                      pinned;
        logic                      lvl;
    } t_probe;

    // Directed samples; all of them stay inside block one, which is zero after reset
    localparam int NumProbes = 20;
    localparam t_probe Probes [NumProbes] = '{
        '{16'sh7fff, 1'b1, 1'b0},   // first sample counts as a crossing
        '{16'sh7fff, 1'b1, 1'b0},   // same sign, no crossing
        '{16'sh8000, 1'b1, 1'b0},   // most negative, second crossing
        '{16'sh0000, 1'b1, 1'b0},   // zero is negative, no crossing
        '{16'sh0001, 1'b0, 1'b0},
        '{16'sh0000, 1'b0, 1'b0},   // zero right after a positive sample
        '{16'sh0001, 1'b0, 1'b0},
        '{16'shffff, 1'b0, 1'b0},
        '{16'sh4000, 1'b0, 1'b0},
        '{16'shc000, 1'b0, 1'b0},
        '{16'sh5555, 1'b0, 1'b0},
        '{16'shaaaa, 1'b0, 1'b0},
        '{16'sh2aaa, 1'b0, 1'b0},
        '{16'shd555, 1'b0, 1'b0},
        '{16'sh00ff, 1'b0, 1'b0},
        '{16'shff00, 1'b0, 1'b0},
        '{16'sh7f00, 1'b0, 1'b0},
        '{16'sh80ff, 1'b0, 1'b0},
        '{16'sh0100, 1'b0, 1'b0},
        '{16'sh0000, 1'b0, 1'b0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CfgIdxW-1:0]        i_cfg_index;
    logic [CfgDataW-1:0]       i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [SampleW-1:0] i_ref_sample;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic                      o_rds_level;

    // Encoder image kept by the testbench
    t_cfg               enc_cfg;
    logic [GroupBits-1:0] enc_group;
    logic [SegW-1:0]    enc_seg;
    int                 enc_bit;
    t_sign              enc_sign;
    logic               enc_half;
    logic               enc_level;
    int                 enc_wraps;

    logic               pending_levels [$];
    logic               want_level;
    logic               pin_now;
    logic               pin_level;

    bit                 tx_calm;
    bit                 rx_calm;
    int                 rx_hold;
    bit                 quiet;
    int                 quiet_cycles;
    int                 mismatches;
    int                 levels_seen;
    int                 samples_sent;
    int                 writes_done;

    rds_group0_bit_encoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ref_sample (i_ref_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_rds_level  (o_rds_level)
    );

    always begin
        i_clk = 1'b0;
        #HalfPeriod;
        i_clk = 1'b1;
        #HalfPeriod;
    end

    // Remainder of data * x^10 over the block check polynomial
    function automatic logic [CheckW-1:0] block_check(input logic [DataW-1:0] d);
        logic [CheckW:0] r;
        r = '0;
        for (int k = DataW - 1; k >= 0; k--) begin
            r = {r[CheckW-1:0], d[k]};
            if (r[CheckW]) begin
                r = r ^ CheckPoly;
            end
        end
        for (int k = 0; k < CheckW; k++) begin
            r = {r[CheckW-1:0], 1'b0};
            if (r[CheckW]) begin
                r = r ^ CheckPoly;
            end
        end
        return r[CheckW-1:0];
    endfunction

    // Four blocks of the group for one segment, first bit sent at the top
    function automatic logic [GroupBits-1:0] assemble_group(input t_cfg c,
                                                            input logic [SegW-1:0] seg);
        logic [DataW-1:0]     words [NumBlocks];
        logic [GroupBits-1:0] g;
        words[0] = c.pi;
        words[1] = {GroupType0, c.ab, c.tp, c.pty, c.ta, c.ms, 1'b0, seg};
        if (seg == SegLast) begin
            words[1] = words[1] | DiStereo;
        end
        words[2] = c.ab ? c.pi : c.af;
        words[3] = DataW'(c.ps >> (48 - 16 * int'(seg)));
        g = '0;
        for (int k = 0; k < NumBlocks; k++) begin
            g = {g[GroupBits-BlockW-1:0], words[k], block_check(words[k])};
        end
        return g;
    endfunction

    // Count crossings; every second one moves to the next group bit
    task automatic advance_encoder(input logic signed [SampleW-1:0] s);
        t_sign sg;
        sg = (s != '0 && !s[SampleW-1]) ? SignPos : SignNeg;
        if (sg != enc_sign) begin
            if (enc_half) begin
                enc_half = 1'b0;
                if (enc_bit == GroupBits - 1) begin
                    enc_bit   = 0;
                    enc_seg   = enc_seg + 2'd1;
                    enc_group = assemble_group(enc_cfg, enc_seg);
                    enc_wraps++;
                end else begin
                    enc_bit++;
                end
                enc_level = enc_level ^ enc_group[GroupBits - 1 - enc_bit];
            end else begin
                enc_half = 1'b1;
            end
        end
        enc_sign = sg;
    endtask

    // Store a register; it only reaches the air at the next group
    task automatic store_setting(input logic [CfgIdxW-1:0] idx,
                                 input logic [CfgDataW-1:0] val);
        case (idx)
            CfgPi:   enc_cfg.pi  = val[PiW-1:0];
            CfgTp:   enc_cfg.tp  = val[0];
            CfgPty:  enc_cfg.pty = val[PtyW-1:0];
            CfgTa:   enc_cfg.ta  = val[0];
            CfgMs:   enc_cfg.ms  = val[0];
            CfgAb:   enc_cfg.ab  = val[0];
            CfgAf:   enc_cfg.af  = val[AfW-1:0];
            CfgPs:   enc_cfg.ps  = val[PsW-1:0];
            default: ;
        endcase
    endtask

    // Check results, follow every accepted item, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet = 1'b1;
            if (o_out_valid && i_out_ready) begin
                quiet = 1'b0;
                levels_seen++;
                if (pending_levels.size() == 0) begin
                    $display("%0t: unexpected level, expected none, got %0b",
                             $time, o_rds_level);
                    mismatches++;
                end else begin
                    want_level = pending_levels.pop_front();
                    if (o_rds_level !== want_level) begin
                        $display("%0t: rds_level mismatch, expected %0b, got %0b",
                                 $time, want_level, o_rds_level);
                        mismatches++;
                    end
                end
                rx_hold = rx_calm ? 0 : $urandom_range(0, MaxIdle);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                quiet = 1'b0;
                store_setting(i_cfg_index, i_cfg_data);
                writes_done++;
            end
            if (i_in_valid && o_in_ready) begin
                quiet = 1'b0;
                advance_encoder(i_ref_sample);
                pending_levels.push_back(pin_now ? pin_level : enc_level);
            end
            quiet_cycles = quiet ? quiet_cycles + 1 : 0;
            if (quiet_cycles >= QuietLimit) begin
                $display("%0t: no item moved for %0d cycles, %0d levels outstanding",
                         $time, QuietLimit, pending_levels.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output side: hold ready low for the drawn number of cycles
    always @(negedge i_clk) begin
        if (i_rst_n && rx_hold == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            if (rx_hold > 0) begin
                rx_hold--;
            end
        end
    end

    // Offer one sample; entered and left at a falling edge
    task automatic send_sample(input logic signed [SampleW-1:0] s,
                               input logic pinned, input logic lvl);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MaxIdle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_ref_sample <= s;
        pin_now      <= pinned;
        pin_level    <= lvl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write every register, with junk above each width and two stray indexes
    task automatic load_settings(input t_cfg c);
        logic [CfgDataW-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CfgNoSuch, junk);
        write_reg(CfgPi,  {junk[CfgDataW-1:PiW], c.pi});
        write_reg(CfgTp,  {junk[CfgDataW-1:1], c.tp});
        write_reg(CfgPty, {junk[CfgDataW-1:PtyW], c.pty});
        write_reg(CfgTa,  {junk[CfgDataW-1:1], c.ta});
        write_reg(CfgMs,  {junk[CfgDataW-1:1], c.ms});
        write_reg(CfgAb,  {junk[CfgDataW-1:1], c.ab});
        write_reg(CfgAf,  {junk[CfgDataW-1:AfW], c.af});
        write_reg(CfgPs,  c.ps);
        write_reg(CfgTopIdx, ~junk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off until every level owed has come back
    task automatic drain();
        while (pending_levels.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_cfg                      setting;
        logic signed [SampleW-1:0] s;
        bit                        tone_pos;
        int                        rand_sent;
        int                        phase;
        int                        pick;

        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_ref_sample = '0;
        i_out_ready  = 1'b0;
        pin_now      = 1'b0;
        pin_level    = 1'b0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        rx_hold      = 0;
        quiet_cycles = 0;
        mismatches   = 0;
        levels_seen  = 0;
        samples_sent = 0;
        writes_done  = 0;

        enc_cfg   = CfgReset;
        enc_seg   = '0;
        enc_bit   = 0;
        enc_sign  = SignNone;
        enc_half  = 1'b0;
        enc_group = assemble_group(CfgReset, '0);
        enc_level = enc_group[GroupBits-1];
        enc_wraps = 0;

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed samples on the reset settings
        for (int k = 0; k < NumProbes; k++) begin
            send_sample(Probes[k].sample, Probes[k].pinned, Probes[k].lvl);
        end
        i_in_valid <= 1'b0;

        // Random tone: phases of new settings, mostly clean sign alternation
        rand_sent = 0;
        phase     = 0;
        tone_pos  = 1'b0;
        while ((rand_sent < RandItems || enc_wraps < SegW + 1) && rand_sent < RandCap) begin
            drain();
            if (phase == 0) begin
                setting = '1;
            end else if (phase == 1) begin
                setting = '0;
            end else begin
                setting.pi  = PiW'($urandom);
                setting.tp  = 1'($urandom);
                setting.pty = PtyW'($urandom);
                setting.ta  = 1'($urandom);
                setting.ms  = 1'($urandom);
                setting.ab  = 1'($urandom);
                setting.af  = AfW'($urandom);
                setting.ps  = {$urandom, $urandom};
            end
            load_settings(setting);
            tx_calm = (phase % 4 == 1) || (phase % 4 == 3);
            rx_calm = (phase % 4 == 2) || (phase % 4 == 3);
            for (int k = 0; k < PhaseItems; k++) begin
                // Flip the sign most of the time; a repeat is a slow tone or noise
                if ($urandom_range(0, 15) != 0) begin
                    tone_pos = !tone_pos;
                end
                pick = $urandom_range(0, 7);
                if (tone_pos) begin
                    if (pick == 0) begin
                        s = 16'sh7fff;
                    end else if (pick == 1) begin
                        s = 16'sh0001;
                    end else begin
                        s = SampleW'($urandom_range(1, 32767));
                    end
                end else begin
                    if (pick == 0) begin
                        s = '0;
                    end else if (pick == 1) begin
                        s = 16'sh8000;
                    end else begin
                        s = {1'b1, 15'($urandom)};
                    end
                end
                send_sample(s, 1'b0, 1'b0);
                rand_sent++;
            end
            i_in_valid <= 1'b0;
            phase++;
        end

        drain();
        repeat (TailCycles) @(posedge i_clk);

        if (pending_levels.size() != 0) begin
            $display("%0t: %0d expected levels never came out", $time,
                     pending_levels.size());
            mismatches++;
        end
        $display("Sent %0d tone samples over %0d settings phases, %0d register writes,",
                 samples_sent, phase, writes_done);
        $display("checked %0d levels across %0d group wraps, last segment %0d.",
                 levels_seen, enc_wraps, enc_seg);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
